>>> rtl/core/sliding_window_patch_extractor_defines.svh
// Assertion macros for the sliding window patch extractor.
// Used by the port checker; expects signals named clk and arst_n in scope.
`ifndef SLIDING_WINDOW_PATCH_EXTRACTOR_DEFINES_SVH
`define SLIDING_WINDOW_PATCH_EXTRACTOR_DEFINES_SVH

// Base form: a property checked on every rising edge outside reset.
`define SWPE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same-cycle implication.
`define SWPE_ASSERT_IMM(label, cond, expr, msg) `SWPE_ASSERT(label, cond |-> expr, msg)

// Next-cycle implication.
`define SWPE_ASSERT_NXT(label, cond, expr, msg) `SWPE_ASSERT(label, cond |=> expr, msg)

`endif

>>> rtl/core/swpe_pkg.sv
// Shared types and constants of the sliding window patch extractor.
// No dependencies; every other file of the block but the assertion macros header refers to it by scoped names.
package swpe_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_RADIUS = 2;
	localparam int DEF_PIXEL_BITS = 16;

	localparam int MAX_HEIGHT = 4096;

	localparam int CFG_WIDTH_BITS  = 11;
	localparam int CFG_HEIGHT_BITS = 13;
	localparam int CFG_RADIUS_BITS = 2;
	localparam int CFG_BORDER_BITS = 9;
	localparam int CFG_DATA_BITS   = 13;
	localparam int CFG_INDEX_BITS  = 2;

	localparam int ROW_BITS = 12;
	localparam int CX_BITS  = 10;
	localparam int CY_BITS  = 12;
	// Row arithmetic needs room for the height plus a margin.
	localparam int YW = CFG_HEIGHT_BITS + 1;

	localparam logic [CFG_WIDTH_BITS-1:0]  RST_FRAME_WIDTH   = 11'd1024;
	localparam logic [CFG_HEIGHT_BITS-1:0] RST_FRAME_HEIGHT  = 13'd1024;
	localparam logic [CFG_RADIUS_BITS-1:0] RST_WINDOW_RADIUS = 2'd1;
	localparam logic [CFG_BORDER_BITS-1:0] RST_EDGE_BORDER   = 9'd0;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_FRAME_WIDTH   = 2'd0,
		REG_FRAME_HEIGHT  = 2'd1,
		REG_WINDOW_RADIUS = 2'd2,
		REG_EDGE_BORDER   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [CFG_WIDTH_BITS-1:0]  frame_width;
		logic [CFG_HEIGHT_BITS-1:0] frame_height;
		logic [CFG_RADIUS_BITS-1:0] window_radius;
		logic [CFG_BORDER_BITS-1:0] edge_border;
	} cfg_t;

	typedef struct packed {
		logic               load;
		logic               first;
		logic               last;
		logic [CX_BITS-1:0] cx;
		logic [CY_BITS-1:0] cy;
	} emit_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_EMIT
	} state_t;

endpackage

>>> rtl/core/swpe_pixel_if.sv
// Pixel request channel of the patch extractor: valid, ready and one pixel.
// Depends on swpe_pkg for the default pixel width.
interface swpe_pixel_if #(
	parameter int PIXEL_BITS = swpe_pkg::DEF_PIXEL_BITS
);
	logic                  valid;
	logic                  ready;
	logic [PIXEL_BITS-1:0] pixel_value;

	modport source (output valid, output pixel_value, input ready);
	modport sink   (input valid, input pixel_value, output ready);
endinterface

>>> rtl/core/swpe_window_if.sv
// Window request channel of the patch extractor: one window value per request.
// Depends on swpe_pkg for field widths.
interface swpe_window_if #(
	parameter int PIXEL_BITS = swpe_pkg::DEF_PIXEL_BITS
);
	logic                         valid;
	logic                         ready;
	logic [PIXEL_BITS-1:0]        window_value;
	logic [swpe_pkg::CX_BITS-1:0] centre_x;
	logic [swpe_pkg::CY_BITS-1:0] centre_y;
	logic                         first_of_window;
	logic                         last_of_window;

	modport source (output valid, output window_value, output centre_x, output centre_y,
		output first_of_window, output last_of_window, input ready);
	modport sink   (input valid, input window_value, input centre_x, input centre_y,
		input first_of_window, input last_of_window, output ready);
endinterface

>>> rtl/core/swpe_line_ram.sv
// Line store of the patch extractor: one entry per column, all buffered rows side by side.
// Synchronous single-port memory, registered read data. Depends on swpe_pkg for default parameters.
module swpe_line_ram #(
	parameter int DEPTH = swpe_pkg::DEF_MAX_WIDTH,
	parameter int DW    = 4 * swpe_pkg::DEF_PIXEL_BITS,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          re,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [DW-1:0] wdata,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

>>> rtl/core/swpe_window.sv
// Window register file: forms the new column, shifts it in and selects one value.
// Depends on swpe_pkg for default parameters.
module swpe_window #(
	parameter int MAX_RADIUS = swpe_pkg::DEF_MAX_RADIUS,
	parameter int PIXEL_BITS = swpe_pkg::DEF_PIXEL_BITS,
	localparam int LINES     = 2 * MAX_RADIUS,
	localparam int SIDE      = 2 * MAX_RADIUS + 1,
	localparam int SW        = $clog2(SIDE)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        shift,
	input  logic [PIXEL_BITS-1:0]       pix,
	input  logic [LINES*PIXEL_BITS-1:0] rd_col,
	input  logic [SW-1:0]               sel_row,
	input  logic [SW-1:0]               sel_col,
	output logic [LINES*PIXEL_BITS-1:0] wr_col,
	output logic [PIXEL_BITS-1:0]       value
);

	logic [PIXEL_BITS-1:0] column [SIDE];
	logic [PIXEL_BITS-1:0] win_q  [SIDE][SIDE];

	// The stored rows plus the arriving pixel; each row moves up by one line.
	always_comb begin
		for (int k = 0; k < LINES; k++) begin
			column[k] = rd_col[k*PIXEL_BITS +: PIXEL_BITS];
		end
		column[LINES] = pix;
		for (int k = 0; k < LINES; k++) begin
			wr_col[k*PIXEL_BITS +: PIXEL_BITS] = column[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SIDE; i++) begin
				for (int j = 0; j < SIDE; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (shift) begin
			for (int i = 0; i < SIDE; i++) begin
				for (int j = 0; j < SIDE - 1; j++) begin
					win_q[i][j] <= win_q[i][j+1];
				end
				win_q[i][SIDE-1] <= column[i];
			end
		end
	end

	assign value = win_q[sel_row][sel_col];

endmodule

>>> rtl/core/swpe_ctrl.sv
// Sequencer of the patch extractor: raster counters, line store access, interior test
// and the walk over one window. Depends on swpe_pkg.
module swpe_ctrl #(
	parameter int MAX_WIDTH  = swpe_pkg::DEF_MAX_WIDTH,
	parameter int MAX_RADIUS = swpe_pkg::DEF_MAX_RADIUS,
	localparam int AW        = $clog2(MAX_WIDTH),
	localparam int SIDE      = 2 * MAX_RADIUS + 1,
	localparam int SW        = $clog2(SIDE)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  swpe_pkg::cfg_t       cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 out_free,
	output logic                 ram_re,
	output logic                 ram_we,
	output logic [AW-1:0]        ram_addr,
	output logic                 shift,
	output logic [SW-1:0]        sel_row,
	output logic [SW-1:0]        sel_col,
	output swpe_pkg::emit_t      emit
);

	localparam int WB  = swpe_pkg::CFG_WIDTH_BITS;
	localparam int XW  = ((AW > WB) ? AW : WB) + 1;
	localparam int YW  = swpe_pkg::YW;
	localparam int RB  = swpe_pkg::CFG_RADIUS_BITS;
	localparam int BB  = swpe_pkg::CFG_BORDER_BITS;
	localparam int RWB = swpe_pkg::ROW_BITS;
	localparam int CXW = swpe_pkg::CX_BITS;
	localparam int CYW = swpe_pkg::CY_BITS;
	localparam logic [SW-1:0] SIDE_M1 = SW'(SIDE - 1);

	swpe_pkg::state_t state_q, state_d;

	logic [AW-1:0]  col_q, col_d;
	logic [RWB-1:0] row_q, row_d;
	logic [SW-1:0]  ri_q, ri_d, cj_q, cj_d, r0_q, r0_d;
	logic [CXW-1:0] cx_q, cx_d;
	logic [CYW-1:0] cy_q, cy_d;

	logic [XW-1:0] w_eff;
	logic [YW-1:0] h_eff;
	logic [RB-1:0] r_eff;
	logic [BB-1:0] b_eff;
	logic          interior;

	// Effective frame geometry, with out-of-range settings clamped.
	always_comb begin
		if (cfg.frame_width == '0) begin
			w_eff = XW'(1);
		end else if (XW'(cfg.frame_width) > XW'(MAX_WIDTH)) begin
			w_eff = XW'(MAX_WIDTH);
		end else begin
			w_eff = XW'(cfg.frame_width);
		end

		if (cfg.frame_height == '0) begin
			h_eff = YW'(1);
		end else if (YW'(cfg.frame_height) > YW'(swpe_pkg::MAX_HEIGHT)) begin
			h_eff = YW'(swpe_pkg::MAX_HEIGHT);
		end else begin
			h_eff = YW'(cfg.frame_height);
		end

		if (cfg.window_radius > RB'(MAX_RADIUS)) begin
			r_eff = RB'(MAX_RADIUS);
		end else begin
			r_eff = cfg.window_radius;
		end

		// A zero border means the radius; a border below the radius is raised to it.
		b_eff = (cfg.edge_border == '0) ? BB'(r_eff) : cfg.edge_border;
		if (b_eff < BB'(r_eff)) begin
			b_eff = BB'(r_eff);
		end
	end

	// Centre (row - r, col - r) is interior when it lies at least b from every edge.
	assign interior = (XW'(col_q) >= XW'(b_eff) + XW'(r_eff))
		&& (XW'(col_q) + XW'(b_eff) < w_eff + XW'(r_eff))
		&& (YW'(row_q) >= YW'(b_eff) + YW'(r_eff))
		&& (YW'(row_q) + YW'(b_eff) < h_eff + YW'(r_eff));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swpe_pkg::ST_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			ri_q    <= '0;
			cj_q    <= '0;
			r0_q    <= '0;
			cx_q    <= '0;
			cy_q    <= '0;
		end else begin
			state_q <= state_d;
			col_q   <= col_d;
			row_q   <= row_d;
			ri_q    <= ri_d;
			cj_q    <= cj_d;
			r0_q    <= r0_d;
			cx_q    <= cx_d;
			cy_q    <= cy_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		col_d      = col_q;
		row_d      = row_q;
		ri_d       = ri_q;
		cj_d       = cj_q;
		r0_d       = r0_q;
		cx_d       = cx_q;
		cy_d       = cy_q;
		in_ready   = 1'b0;
		ram_re     = 1'b0;
		ram_we     = 1'b0;
		shift      = 1'b0;
		emit.load  = 1'b0;
		emit.first = (ri_q == r0_q) && (cj_q == r0_q);
		emit.last  = (ri_q == SIDE_M1) && (cj_q == SIDE_M1);
		emit.cx    = cx_q;
		emit.cy    = cy_q;

		unique case (state_q)
			swpe_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ram_re  = 1'b1;
					state_d = swpe_pkg::ST_UPDATE;
				end
			end
			swpe_pkg::ST_UPDATE: begin
				ram_we = 1'b1;
				shift  = 1'b1;
				cx_d   = CXW'(XW'(col_q) - XW'(r_eff));
				cy_d   = CYW'(YW'(row_q) - YW'(r_eff));
				// The window occupies the newest rows and columns of the register file.
				r0_d   = SIDE_M1 - (SW'(r_eff) << 1);
				ri_d   = SIDE_M1 - (SW'(r_eff) << 1);
				cj_d   = SIDE_M1 - (SW'(r_eff) << 1);
				if (XW'(col_q) + XW'(1) >= w_eff) begin
					col_d = '0;
					if (YW'(row_q) + YW'(1) >= h_eff) begin
						row_d = '0;
					end else begin
						row_d = row_q + RWB'(1);
					end
				end else begin
					col_d = col_q + AW'(1);
				end
				state_d = interior ? swpe_pkg::ST_EMIT : swpe_pkg::ST_IDLE;
			end
			swpe_pkg::ST_EMIT: begin
				if (out_free) begin
					emit.load = 1'b1;
					if (cj_q == SIDE_M1) begin
						if (ri_q == SIDE_M1) begin
							state_d = swpe_pkg::ST_IDLE;
						end else begin
							ri_d = ri_q + SW'(1);
							cj_d = r0_q;
						end
					end else begin
						cj_d = cj_q + SW'(1);
					end
				end
			end
			default: begin
				state_d = swpe_pkg::ST_IDLE;
			end
		endcase
	end

	assign ram_addr = col_q;
	assign sel_row  = ri_q;
	assign sel_col  = cj_q;

endmodule

>>> rtl/core/sliding_window_patch_extractor.sv
// Sliding window patch extractor: streaming window extraction over a raster frame.
// Depends on swpe_pkg, swpe_pixel_if, swpe_window_if, swpe_line_ram, swpe_window, swpe_ctrl.
//
// Pixels arrive one per request in raster order. The block keeps the previous 2*MAX_RADIUS
// rows in a single-port line memory, one entry per column holding all buffered rows, and
// the newest 2*MAX_RADIUS+1 columns in a window register file. When the pixel at
// (y+r, x+r) arrives and (y, x) is at least the effective border from every frame edge,
// the (2r+1)x(2r+1) window around (y, x) leaves in row-major order, one value per
// request, with the first and last values flagged. The effective border is edge_border,
// or the radius when edge_border is zero, and never less than the radius. Pixels are
// handled one at a time: each takes a line memory read, then write-back and window
// shift, and one that completes a window then hands its (2r+1)^2 values through the
// single output register, one window value per cycle while the output side is ready.
// The next pixel is taken while the last value of a window still waits in the output
// register. Line memory contents are undefined after reset and need no clearing pass;
// the first frame after reset never reads an unwritten entry into a window.
// Configuration is to be written by the user only while the block is idle; the block
// itself does not enforce this.
module sliding_window_patch_extractor #(
	parameter int MAX_WIDTH  = swpe_pkg::DEF_MAX_WIDTH,
	parameter int MAX_RADIUS = swpe_pkg::DEF_MAX_RADIUS,
	parameter int PIXEL_BITS = swpe_pkg::DEF_PIXEL_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [swpe_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [swpe_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	swpe_pixel_if.sink                          pixel_in,
	swpe_window_if.source                       window_out
);

	localparam int AW    = $clog2(MAX_WIDTH);
	localparam int LINES = 2 * MAX_RADIUS;
	localparam int SIDE  = 2 * MAX_RADIUS + 1;
	localparam int SW    = $clog2(SIDE);
	localparam int DW    = LINES * PIXEL_BITS;

	// Configuration registers.
	swpe_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width   <= swpe_pkg::RST_FRAME_WIDTH;
			cfg_q.frame_height  <= swpe_pkg::RST_FRAME_HEIGHT;
			cfg_q.window_radius <= swpe_pkg::RST_WINDOW_RADIUS;
			cfg_q.edge_border   <= swpe_pkg::RST_EDGE_BORDER;
		end else if (cfg_we) begin
			unique case (swpe_pkg::cfg_reg_t'(cfg_index))
				swpe_pkg::REG_FRAME_WIDTH: begin
					cfg_q.frame_width <= cfg_wdata[swpe_pkg::CFG_WIDTH_BITS-1:0];
				end
				swpe_pkg::REG_FRAME_HEIGHT: begin
					cfg_q.frame_height <= cfg_wdata[swpe_pkg::CFG_HEIGHT_BITS-1:0];
				end
				swpe_pkg::REG_WINDOW_RADIUS: begin
					cfg_q.window_radius <= cfg_wdata[swpe_pkg::CFG_RADIUS_BITS-1:0];
				end
				swpe_pkg::REG_EDGE_BORDER: begin
					cfg_q.edge_border <= cfg_wdata[swpe_pkg::CFG_BORDER_BITS-1:0];
				end
			endcase
		end
	end

	logic                  in_ready;
	logic                  in_fire;
	logic [PIXEL_BITS-1:0] pix_q;
	logic                  out_valid_q;
	logic                  out_free;
	logic                  ram_re;
	logic                  ram_we;
	logic [AW-1:0]         ram_addr;
	logic [DW-1:0]         ram_rdata;
	logic [DW-1:0]         ram_wdata;
	logic                  shift;
	logic [SW-1:0]         sel_row;
	logic [SW-1:0]         sel_col;
	logic [PIXEL_BITS-1:0] win_value;
	swpe_pkg::emit_t       emit;

	assign pixel_in.ready = in_ready;
	assign in_fire        = pixel_in.valid && in_ready;

	// The accepted pixel is held until the write-back cycle.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			pix_q <= pixel_in.pixel_value;
		end
	end

	swpe_line_ram #(
		.DEPTH (MAX_WIDTH),
		.DW    (DW)
	) u_line_ram (
		.clk   (clk),
		.re    (ram_re),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	swpe_window #(
		.MAX_RADIUS (MAX_RADIUS),
		.PIXEL_BITS (PIXEL_BITS)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift   (shift),
		.pix     (pix_q),
		.rd_col  (ram_rdata),
		.sel_row (sel_row),
		.sel_col (sel_col),
		.wr_col  (ram_wdata),
		.value   (win_value)
	);

	swpe_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_RADIUS (MAX_RADIUS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (pixel_in.valid),
		.in_ready (in_ready),
		.out_free (out_free),
		.ram_re   (ram_re),
		.ram_we   (ram_we),
		.ram_addr (ram_addr),
		.shift    (shift),
		.sel_row  (sel_row),
		.sel_col  (sel_col),
		.emit     (emit)
	);

	// Output register: it takes a new value whenever it is empty or being drained.
	assign out_free = !out_valid_q || window_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.load) begin
			out_valid_q <= 1'b1;
		end else if (window_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.load) begin
			window_out.window_value    <= win_value;
			window_out.centre_x        <= emit.cx;
			window_out.centre_y        <= emit.cy;
			window_out.first_of_window <= emit.first;
			window_out.last_of_window  <= emit.last;
		end
	end

	assign window_out.valid = out_valid_q;

endmodule

>>> rtl/core/swpe_checker.sv
// Port checker of the patch extractor, attached to the top level by the bind below.
// Depends on swpe_pkg and the assertion macros header.
`include "sliding_window_patch_extractor_defines.svh"

module swpe_checker #(
	parameter int PIXEL_BITS = swpe_pkg::DEF_PIXEL_BITS
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [PIXEL_BITS-1:0]        out_value,
	input logic [swpe_pkg::CX_BITS-1:0] out_cx,
	input logic [swpe_pkg::CY_BITS-1:0] out_cy,
	input logic                         out_first,
	input logic                         out_last
);

	// A stalled window value stays offered and unchanged.
	`SWPE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "window request dropped while stalled")
	`SWPE_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_value) && $stable(out_cx) && $stable(out_cy) && $stable(out_first) && $stable(out_last), "window payload changed while stalled")

	// While a window is only partly delivered, no new pixel may enter.
	`SWPE_ASSERT_IMM(a_window_blocks_input, out_valid && !out_last, !in_ready, "pixel taken in the middle of a window")

	// Each pixel needs its write-back cycle before the next one is taken.
	`SWPE_ASSERT_NXT(a_one_pixel_at_a_time, in_valid && in_ready, !in_ready, "pixel taken during write-back")

endmodule

bind sliding_window_patch_extractor swpe_checker #(
	.PIXEL_BITS (PIXEL_BITS)
) u_swpe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixel_in.valid),
	.in_ready  (pixel_in.ready),
	.out_valid (window_out.valid),
	.out_ready (window_out.ready),
	.out_value (window_out.window_value),
	.out_cx    (window_out.centre_x),
	.out_cy    (window_out.centre_y),
	.out_first (window_out.first_of_window),
	.out_last  (window_out.last_of_window)
);
